### rtl/core/digitizer_event_unpacker_macros.svh
// Assertion macros for the digitizer event unpacker.
`ifndef DIGITIZER_EVENT_UNPACKER_MACROS_SVH
`define DIGITIZER_EVENT_UNPACKER_MACROS_SVH
`ifndef SYNTH
`define DEU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define DEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DEU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define DEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/deu_pkg.sv
// Types and constants of the digitizer event unpacker.
package deu_pkg;

    localparam int SAMPLES = 1024;
    localparam int GROUPS  = 4;

    localparam int W_TR_I    = (12 * SAMPLES + 31) / 32;
    localparam int TR_LAST_I = SAMPLES - (32 * (W_TR_I - 1)) / 12;

    localparam logic [11:0] W_CH         = 12'(3 * SAMPLES);
    localparam logic [11:0] W_TR         = 12'(W_TR_I);
    localparam logic [1:0]  TR_LAST      = 2'(TR_LAST_I);
    localparam logic [3:0]  GROUP_ENABLE = 4'((1 << GROUPS) - 1);

    localparam logic [2:0] K_EVENT_ID     = 3'd0;
    localparam logic [2:0] K_EVENT_TIME   = 3'd1;
    localparam logic [2:0] K_GROUP_HEADER = 3'd2;
    localparam logic [2:0] K_SAMPLE       = 3'd3;
    localparam logic [2:0] K_TRIG_SAMPLE  = 3'd4;
    localparam logic [2:0] K_GROUP_TAG    = 3'd5;
    localparam logic [2:0] K_ERROR        = 3'd6;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_HEAD = 6'b000010,
        PH_GRP  = 6'b000100,
        PH_CHAN = 6'b001000,
        PH_TRIG = 6'b010000,
        PH_TAG  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [31:0] stream_word;
        logic        start_of_event;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  group;
        logic [2:0]  channel;
        logic [9:0]  sample_index;
        logic [11:0] value;
        logic [4:0]  board_num;
        logic [13:0] pattern;
        logic [31:0] tag;
        logic [1:0]  frequency;
        logic        trigger_present;
        logic [9:0]  start_cell;
        logic        end_of_event;
    } t_result;

endpackage

### rtl/core/digitizer_event_unpacker.sv
// Digitizer event unpacker: header parsing and 12-bit sample unpacking of one event.
//
//  Channel | Direction | Handshake         | Payload
//  input   | in        | i_valid / o_stall | i_item   (deu_pkg::t_in_item)
//  output  | out       | o_valid / i_stall | o_result (deu_pkg::t_result)
//
// A word is taken into an input register, decoded combinationally, and its results
// (0 to 3) are loaded into a three-entry result buffer that drains one transfer per
// cycle while the output is not stalled. A word giving n results holds the output until
// all n are taken, so header and tag words run at one per cycle when not stalled.
// Synchronous active-low reset returns the block to idle with an empty buffer.
// A stall on the output holds the buffer and, while it is not empty, stalls the input.
`include "digitizer_event_unpacker_macros.svh"

module digitizer_event_unpacker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  deu_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output deu_pkg::t_result  o_result
);
    import deu_pkg::*;

    function automatic logic [2:0] f_next_group(input logic [3:0] mask, input logic [2:0] from);
        logic [2:0] res;
        res = 3'b000;
        for (int g = 3; g >= 0; g--) begin
            if (mask[g] && (3'(g) >= from)) begin
                res = {1'b1, 2'(g)};
            end
        end
        return res;
    endfunction

    function automatic t_result f_base(input logic [2:0] kind, input logic [1:0] group,
                                       input logic [4:0] board, input logic [13:0] pattern);
        t_result r;
        r           = '0;
        r.kind      = kind;
        r.group     = group;
        r.board_num = board;
        r.pattern   = pattern;
        return r;
    endfunction

    logic        r_in_vld;
    t_in_item    r_in;
    t_result     r_res [3];
    logic [1:0]  r_cnt;

    t_phase      r_phase,   n_phase;
    logic [1:0]  r_hp,      n_hp;
    logic [4:0]  r_board,   n_board;
    logic [13:0] r_pattern, n_pattern;
    logic [3:0]  r_mask,    n_mask;
    logic [1:0]  r_group,   n_group;
    logic [11:0] r_len,     n_len;
    logic        r_trig,    n_trig;
    logic [11:0] r_wc,      n_wc;
    logic [11:0] r_resid,   n_resid;
    logic [3:0]  r_rc,      n_rc;
    logic [9:0]  r_sc,      n_sc;
    logic [2:0]  r_ch,      n_ch;

    t_result     n_res [3];
    logic [1:0]  n_cnt;

    logic        w_free;
    logic        w_load;
    logic        w_take;
    logic        w_in_acc;

    logic [31:0] w_word;
    logic [47:0] w_acc;
    logic        w_is_trig;
    logic [1:0]  w_avail;
    logic [1:0]  w_nsamp;
    logic [5:0]  w_bits;
    logic [5:0]  w_used;
    logic [5:0]  w_bits_after;
    logic [11:0] w_resid_next;
    logic [3:0]  w_rc_next;
    logic [3:0]  w_ch_sum;
    logic [9:0]  w_sc_next;
    logic [2:0]  w_ch_next;
    t_result     w_samp [3];
    logic [2:0]  w_ng;
    logic        w_grp_err;

    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_res[0];
    assign w_take   = o_valid && !i_stall;
    assign w_free   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);
    assign w_load   = r_in_vld && w_free;
    assign o_stall  = r_in_vld && !w_free;
    assign w_in_acc = i_valid && !o_stall;

    assign w_word    = r_in.stream_word;
    assign w_is_trig = (r_phase == PH_TRIG);
    assign w_acc     = ({16'b0, w_word} << r_rc) | {36'b0, r_resid};
    assign w_avail   = (r_rc >= 4'd4) ? 2'd3 : 2'd2;
    assign w_bits    = 6'd32 + {2'b00, r_rc};

    always_comb begin
        w_nsamp = w_avail;
        if (w_is_trig && (r_wc == (W_TR - 12'd1)) && (TR_LAST < w_avail)) begin
            w_nsamp = TR_LAST;
        end
    end

    always_comb begin
        unique case (w_nsamp)
            2'd0: begin
                w_used       = 6'd0;
                w_resid_next = w_acc[11:0];
            end
            2'd1: begin
                w_used       = 6'd12;
                w_resid_next = w_acc[23:12];
            end
            2'd2: begin
                w_used       = 6'd24;
                w_resid_next = w_acc[35:24];
            end
            default: begin
                w_used       = 6'd36;
                w_resid_next = w_acc[47:36];
            end
        endcase
    end

    assign w_bits_after = w_bits - w_used;
    assign w_rc_next    = (w_bits_after >= 6'd12) ? 4'd0 : w_bits_after[3:0];
    assign w_ch_sum     = {1'b0, r_ch} + {2'b00, w_nsamp};
    assign w_ch_next    = w_is_trig ? r_ch : w_ch_sum[2:0];
    assign w_sc_next    = w_is_trig ? (r_sc + {8'b0, w_nsamp}) : (r_sc + {9'b0, w_ch_sum[3]});

    always_comb begin
        logic [3:0] ch_k;
        for (int k = 0; k < 3; k++) begin
            ch_k = {1'b0, r_ch} + 4'(k);
            w_samp[k] = f_base(w_is_trig ? K_TRIG_SAMPLE : K_SAMPLE, r_group, r_board,
                               r_pattern);
            w_samp[k].value = w_acc[12 * k +: 12];
            if (w_is_trig) begin
                w_samp[k].sample_index = r_sc + 10'(k);
            end else begin
                w_samp[k].channel      = ch_k[2:0];
                w_samp[k].sample_index = r_sc + {9'b0, ch_k[3]};
            end
        end
    end

    assign w_grp_err = (w_word[11:0] < W_CH) || (w_word[12] && ({3'b0, w_word[11:3]} < W_TR));

    always_comb begin
        n_phase   = r_phase;
        n_hp      = r_hp;
        n_board   = r_board;
        n_pattern = r_pattern;
        n_mask    = r_mask;
        n_group   = r_group;
        n_len     = r_len;
        n_trig    = r_trig;
        n_wc      = r_wc;
        n_resid   = r_resid;
        n_rc      = r_rc;
        n_sc      = r_sc;
        n_ch      = r_ch;
        n_cnt     = 2'd0;
        w_ng      = 3'b000;
        for (int k = 0; k < 3; k++) begin
            n_res[k] = f_base(K_EVENT_ID, 2'd0, r_board, r_pattern);
        end

        if (r_in.start_of_event) begin
            n_phase   = PH_HEAD;
            n_hp      = 2'd1;
            n_board   = '0;
            n_pattern = '0;
            n_mask    = '0;
            n_group   = '0;
            n_len     = '0;
            n_trig    = 1'b0;
            n_wc      = '0;
            n_resid   = '0;
            n_rc      = '0;
            n_sc      = '0;
            n_ch      = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_HEAD: begin
                    priority if (r_hp == 2'd1) begin
                        n_board   = w_word[31:27];
                        n_pattern = w_word[21:8];
                        n_mask    = w_word[3:0] & GROUP_ENABLE;
                        n_hp      = 2'd2;
                    end else if (r_hp == 2'd2) begin
                        n_res[0].tag = {10'b0, w_word[21:0]};
                        n_cnt        = 2'd1;
                        n_hp         = 2'd3;
                    end else begin
                        w_ng = f_next_group(r_mask, 3'd0);
                        n_res[0] = f_base(K_EVENT_TIME, 2'd0, r_board, r_pattern);
                        n_res[0].tag = w_word;
                        n_cnt        = 2'd1;
                        if (!w_ng[2]) begin
                            n_res[0].end_of_event = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_group = w_ng[1:0];
                            n_phase = PH_GRP;
                        end
                    end
                end
                PH_GRP: begin
                    n_res[0] = f_base(K_GROUP_HEADER, r_group, r_board, r_pattern);
                    n_res[0].value           = w_word[11:0];
                    n_res[0].frequency       = w_word[17:16];
                    n_res[0].trigger_present = w_word[12];
                    n_res[0].start_cell      = w_word[29:20];
                    n_cnt = 2'd1;
                    if (w_grp_err) begin
                        n_res[1] = f_base(K_ERROR, r_group, r_board, r_pattern);
                        n_res[1].end_of_event = 1'b1;
                        n_cnt   = 2'd2;
                        n_phase = PH_IDLE;
                    end else begin
                        n_len   = w_word[11:0];
                        n_trig  = w_word[12];
                        n_wc    = '0;
                        n_resid = '0;
                        n_rc    = '0;
                        n_sc    = '0;
                        n_ch    = '0;
                        n_phase = PH_CHAN;
                    end
                end
                PH_CHAN, PH_TRIG: begin
                    if ((w_is_trig && (r_wc < W_TR)) || (!w_is_trig && (r_wc < W_CH))) begin
                        n_res   = w_samp;
                        n_cnt   = w_nsamp;
                        n_resid = w_resid_next;
                        n_rc    = w_rc_next;
                        n_sc    = w_sc_next;
                        n_ch    = w_ch_next;
                    end
                    n_wc = r_wc + 12'd1;
                    if ((w_is_trig && (n_wc >= {3'b0, r_len[11:3]})) ||
                        (!w_is_trig && (n_wc >= r_len))) begin
                        n_wc    = '0;
                        n_resid = '0;
                        n_rc    = '0;
                        n_sc    = '0;
                        n_ch    = '0;
                        n_phase = (!w_is_trig && r_trig) ? PH_TRIG : PH_TAG;
                    end
                end
                PH_TAG: begin
                    w_ng = f_next_group(r_mask, {1'b0, r_group} + 3'd1);
                    n_res[0] = f_base(K_GROUP_TAG, r_group, r_board, r_pattern);
                    n_res[0].tag = w_word;
                    n_cnt        = 2'd1;
                    if (!w_ng[2]) begin
                        n_res[0].end_of_event = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_group = w_ng[1:0];
                        n_phase = PH_GRP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_cnt     <= 2'd0;
            r_phase   <= PH_IDLE;
            r_hp      <= '0;
            r_board   <= '0;
            r_pattern <= '0;
            r_mask    <= '0;
            r_group   <= '0;
            r_len     <= '0;
            r_trig    <= 1'b0;
            r_wc      <= '0;
            r_resid   <= '0;
            r_rc      <= '0;
            r_sc      <= '0;
            r_ch      <= '0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_load) begin
                r_in_vld <= 1'b0;
            end
            if (w_load) begin
                r_cnt     <= n_cnt;
                r_phase   <= n_phase;
                r_hp      <= n_hp;
                r_board   <= n_board;
                r_pattern <= n_pattern;
                r_mask    <= n_mask;
                r_group   <= n_group;
                r_len     <= n_len;
                r_trig    <= n_trig;
                r_wc      <= n_wc;
                r_resid   <= n_resid;
                r_rc      <= n_rc;
                r_sc      <= n_sc;
                r_ch      <= n_ch;
            end else if (w_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_item;
        end
        if (w_load) begin
            r_res <= n_res;
        end else if (w_take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    `DEU_ASSERT_NEXT(a_cnt_held, i_clk, i_rst_n, o_valid && i_stall, r_cnt == $past(r_cnt), "result count changed while the output was stalled")
    `DEU_ASSERT_SAME(a_rc_range, i_clk, i_rst_n, 1'b1, r_rc < 4'd12, "residue bit count reached a full sample")
    `DEU_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_vld && !w_load, r_in_vld, "input register lost a word that was not decoded")

endmodule
